### sv/sic_pkg.sv
package sic_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int POINT_W        = 32;

    localparam logic signed [POINT_W-1:0] POINT_MAX = 32'sh7fff_ffff;
    localparam logic signed [POINT_W-1:0] POINT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_CROSS  = 2'd1,
        KIND_VERTEX = 2'd2,
        KIND_EDGE   = 2'd3
    } kind_t;

    // Classification result that rides along with the point arithmetic
    typedef struct packed {
        kind_t                     kind;
        logic                      par;
        logic signed [POINT_W-1:0] ppx;
        logic signed [POINT_W-1:0] ppy;
    } side_t;

endpackage

### sv/sic_seg_if.sv
interface sic_seg_if #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] dy;

    modport source (output valid, ax, ay, bx, by, cx, cy, dx, dy, input ready);
    modport sink   (input valid, ax, ay, bx, by, cx, cy, dx, dy, output ready);
endinterface

### sv/sic_res_if.sv
interface sic_res_if ();
    logic                                       valid;
    logic                                       ready;
    sic_pkg::kind_t                             kind;
    logic signed [sic_pkg::POINT_W-1:0]         point_x;
    logic signed [sic_pkg::POINT_W-1:0]         point_y;

    modport source (output valid, kind, point_x, point_y, input ready);
    modport sink   (input valid, kind, point_x, point_y, output ready);
endinterface

### sv/sic_front.sv
module sic_front #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    sic_seg_if.sink                        seg_in,
    input  logic                           q_full,
    output logic                           q_push,
    output logic signed [COORD_BITS-1:0]   f_pt [4],
    output logic signed [2*COORD_BITS+2:0] f_ns,
    output logic signed [2*COORD_BITS+2:0] f_den,
    output sic_pkg::side_t                 f_side
);

    localparam int CW  = COORD_BITS;
    localparam int DFW = CW + 1;
    localparam int PW  = 2 * CW + 2;
    localparam int DW  = 2 * CW + 3;

    localparam logic signed [DW-1:0] DZ = '0;

    localparam int AX = 0, AY = 1, BX = 2, BY = 3, CX = 4, CY = 5, DX = 6, DY = 7;
    localparam int BAX = 0, BAY = 1, DCX = 2, DCY = 3, ACX = 4, ACY = 5;
    localparam int CAX = 6, CAY = 7, DAX = 8, DAY = 9, BCX = 10, BCY = 11;

    function automatic logic signed [DFW-1:0] dsub(input logic signed [CW-1:0] p,
                                                   input logic signed [CW-1:0] q);
        return DFW'(p) - DFW'(q);
    endfunction

    // Inclusive betweenness on x, or on y when the segment is vertical
    function automatic logic btw(input logic signed [CW-1:0] px, py, qx, qy, rx, ry);
        logic signed [CW-1:0] pk, qk, rk;
        if (px != qx)
        begin
            pk = px; qk = qx; rk = rx;
        end
        else
        begin
            pk = py; qk = qy; rk = ry;
        end
        return (pk <= rk && rk <= qk) || (pk >= rk && rk >= qk);
    endfunction

    function automatic logic signed [sic_pkg::POINT_W-1:0] scale_sat(
        input logic signed [CW-1:0] v);
        logic signed [63:0] w;
        w = 64'(v) <<< FRAC_BITS;
        if (w > 64'sd2147483647)
            return sic_pkg::POINT_MAX;
        else if (w < -64'sd2147483648)
            return sic_pkg::POINT_MIN;
        else
            return w[sic_pkg::POINT_W-1:0];
    endfunction

    logic                   fe;
    logic signed [CW-1:0]   pt_next [8];
    logic signed [DFW-1:0]  dif_next [12];
    logic signed [PW-1:0]   prod_next [10];

    logic                   s1_v_reg, s2_v_reg, s3_v_reg;
    logic signed [CW-1:0]   s1_pt_reg [8];
    logic signed [CW-1:0]   s2_pt_reg [8];
    logic signed [CW-1:0]   s3_pt_reg [8];
    logic signed [DFW-1:0]  s1_dif_reg [12];
    logic signed [PW-1:0]   s2_prod_reg [10];
    logic signed [DW-1:0]   s3_den_reg, s3_ns_reg, s3_nt_reg, s3_abd_reg, s3_cdb_reg;

    assign fe           = !s3_v_reg || !q_full;
    assign seg_in.ready = fe;
    assign q_push       = s3_v_reg && fe;

    always_comb
    begin
        pt_next[AX] = seg_in.ax;
        pt_next[AY] = seg_in.ay;
        pt_next[BX] = seg_in.bx;
        pt_next[BY] = seg_in.by;
        pt_next[CX] = seg_in.cx;
        pt_next[CY] = seg_in.cy;
        pt_next[DX] = seg_in.dx;
        pt_next[DY] = seg_in.dy;
        dif_next[BAX] = dsub(pt_next[BX], pt_next[AX]);
        dif_next[BAY] = dsub(pt_next[BY], pt_next[AY]);
        dif_next[DCX] = dsub(pt_next[DX], pt_next[CX]);
        dif_next[DCY] = dsub(pt_next[DY], pt_next[CY]);
        dif_next[ACX] = dsub(pt_next[AX], pt_next[CX]);
        dif_next[ACY] = dsub(pt_next[AY], pt_next[CY]);
        dif_next[CAX] = dsub(pt_next[CX], pt_next[AX]);
        dif_next[CAY] = dsub(pt_next[CY], pt_next[AY]);
        dif_next[DAX] = dsub(pt_next[DX], pt_next[AX]);
        dif_next[DAY] = dsub(pt_next[DY], pt_next[AY]);
        dif_next[BCX] = dsub(pt_next[BX], pt_next[CX]);
        dif_next[BCY] = dsub(pt_next[BY], pt_next[CY]);
    end

    always_comb
    begin
        prod_next[0] = s1_dif_reg[BAY] * s1_dif_reg[DCX];
        prod_next[1] = s1_dif_reg[BAX] * s1_dif_reg[DCY];
        prod_next[2] = s1_dif_reg[ACX] * s1_dif_reg[DCY];
        prod_next[3] = s1_dif_reg[DCX] * s1_dif_reg[ACY];
        prod_next[4] = s1_dif_reg[BAX] * s1_dif_reg[CAY];
        prod_next[5] = s1_dif_reg[BAY] * s1_dif_reg[CAX];
        prod_next[6] = s1_dif_reg[BAX] * s1_dif_reg[DAY];
        prod_next[7] = s1_dif_reg[BAY] * s1_dif_reg[DAX];
        prod_next[8] = s1_dif_reg[DCX] * s1_dif_reg[BCY];
        prod_next[9] = s1_dif_reg[DCY] * s1_dif_reg[BCX];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (fe)
        begin
            s1_v_reg <= seg_in.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            s1_pt_reg   <= pt_next;
            s1_dif_reg  <= dif_next;
            s2_pt_reg   <= s1_pt_reg;
            s2_prod_reg <= prod_next;
            s3_pt_reg   <= s2_pt_reg;
            s3_den_reg  <= DW'(s2_prod_reg[0]) - DW'(s2_prod_reg[1]);
            s3_ns_reg   <= DW'(s2_prod_reg[2]) - DW'(s2_prod_reg[3]);
            s3_nt_reg   <= DW'(s2_prod_reg[4]) - DW'(s2_prod_reg[5]);
            s3_abd_reg  <= DW'(s2_prod_reg[6]) - DW'(s2_prod_reg[7]);
            s3_cdb_reg  <= DW'(s2_prod_reg[8]) - DW'(s2_prod_reg[9]);
        end
    end

    logic signed [DW-1:0] ns_n, nt_n;
    logic                 online, hit_c, hit_d, hit_a, hit_b;
    logic signed [CW-1:0] hx, hy;
    sic_pkg::kind_t       kind_np;

    always_comb
    begin
        // flip signs so the common denominator is positive
        if (s3_den_reg[DW-1])
        begin
            f_den = -s3_den_reg;
            ns_n  = -s3_ns_reg;
            nt_n  = -s3_nt_reg;
        end
        else
        begin
            f_den = s3_den_reg;
            ns_n  = s3_ns_reg;
            nt_n  = s3_nt_reg;
        end
        f_ns = ns_n;

        if (ns_n > DZ && ns_n < f_den && nt_n > DZ && nt_n < f_den)
            kind_np = sic_pkg::KIND_CROSS;
        else if (ns_n < DZ || ns_n > f_den || nt_n < DZ || nt_n > f_den)
            kind_np = sic_pkg::KIND_NONE;
        else
            kind_np = sic_pkg::KIND_VERTEX;

        // cross(d-c, a-c) is the negated s numerator
        online = (s3_nt_reg == '0);
        hit_c  = online && btw(s3_pt_reg[AX], s3_pt_reg[AY], s3_pt_reg[BX], s3_pt_reg[BY],
                               s3_pt_reg[CX], s3_pt_reg[CY]);
        hit_d  = online && (s3_abd_reg == '0) &&
                 btw(s3_pt_reg[AX], s3_pt_reg[AY], s3_pt_reg[BX], s3_pt_reg[BY],
                     s3_pt_reg[DX], s3_pt_reg[DY]);
        hit_a  = online && (s3_ns_reg == '0) &&
                 btw(s3_pt_reg[CX], s3_pt_reg[CY], s3_pt_reg[DX], s3_pt_reg[DY],
                     s3_pt_reg[AX], s3_pt_reg[AY]);
        hit_b  = online && (s3_cdb_reg == '0) &&
                 btw(s3_pt_reg[CX], s3_pt_reg[CY], s3_pt_reg[DX], s3_pt_reg[DY],
                     s3_pt_reg[BX], s3_pt_reg[BY]);

        if (hit_c)
        begin
            hx = s3_pt_reg[CX]; hy = s3_pt_reg[CY];
        end
        else if (hit_d)
        begin
            hx = s3_pt_reg[DX]; hy = s3_pt_reg[DY];
        end
        else if (hit_a)
        begin
            hx = s3_pt_reg[AX]; hy = s3_pt_reg[AY];
        end
        else
        begin
            hx = s3_pt_reg[BX]; hy = s3_pt_reg[BY];
        end

        f_side.par = (s3_den_reg == '0);
        if (!f_side.par)
        begin
            f_side.kind = kind_np;
            f_side.ppx  = '0;
            f_side.ppy  = '0;
        end
        else if (hit_c || hit_d || hit_a || hit_b)
        begin
            f_side.kind = sic_pkg::KIND_EDGE;
            f_side.ppx  = scale_sat(hx);
            f_side.ppy  = scale_sat(hy);
        end
        else
        begin
            f_side.kind = sic_pkg::KIND_NONE;
            f_side.ppx  = '0;
            f_side.ppy  = '0;
        end

        f_pt[0] = s3_pt_reg[AX];
        f_pt[1] = s3_pt_reg[AY];
        f_pt[2] = s3_pt_reg[BX];
        f_pt[3] = s3_pt_reg[BY];
    end

endmodule

### sv/sic_queue.sv
module sic_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = sic_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg, wr_next, rd_next;
    logic [AW:0]      cnt_reg, cnt_next;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rd_reg];

    always_comb
    begin
        wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_next;
            if (pop)
                rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= wdata;
    end

endmodule

### sv/sic_div.sv
module sic_div #(
    parameter int NUM_W = 66,
    parameter int DEN_W = 35
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [NUM_W-1:0]                   num [2],
    input  logic                               neg [2],
    input  logic [DEN_W-1:0]                   den,
    input  sic_pkg::side_t                     side_in,
    output logic                               out_valid,
    output logic signed [sic_pkg::POINT_W-1:0] quo [2],
    output sic_pkg::side_t                     side_out
);

    localparam int QW = sic_pkg::POINT_W;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [DEN_W:0] step(input logic [DEN_W-1:0] rem,
                                            input logic nb,
                                            input logic [DEN_W-1:0] d);
        logic [DEN_W:0] trial, diff;
        trial = {rem, nb};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d})
            return {1'b1, diff[DEN_W-1:0]};
        else
            return {1'b0, trial[DEN_W-1:0]};
    endfunction

    logic                 v_reg    [NUM_W+1];
    logic [NUM_W-1:0]     num_reg  [NUM_W+1][2];
    logic [DEN_W-1:0]     rem_reg  [NUM_W+1][2];
    logic [QW-1:0]        q_reg    [NUM_W+1][2];
    logic                 ov_reg   [NUM_W+1][2];
    logic                 neg_reg  [NUM_W+1][2];
    logic [DEN_W-1:0]     den_reg  [NUM_W+1];
    sic_pkg::side_t       side_reg [NUM_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 2; i++)
            begin
                num_reg[0][i] <= num[i];
                rem_reg[0][i] <= '0;
                q_reg[0][i]   <= '0;
                ov_reg[0][i]  <= 1'b0;
                neg_reg[0][i] <= neg[i];
            end
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic [DEN_W:0] res_next [2];

        always_comb
        begin
            for (int i = 0; i < 2; i++)
                res_next[i] = step(rem_reg[k][i], num_reg[k][i][NUM_W-1], den_reg[k]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    num_reg[k+1][i] <= num_reg[k][i] << 1;
                    rem_reg[k+1][i] <= res_next[i][DEN_W-1:0];
                    q_reg[k+1][i]   <= {q_reg[k][i][QW-2:0], res_next[i][DEN_W]};
                    // remember any quotient bit that leaves the 32-bit window
                    ov_reg[k+1][i]  <= ov_reg[k][i] | q_reg[k][i][QW-1];
                    neg_reg[k+1][i] <= neg_reg[k][i];
                end
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign side_out  = side_reg[NUM_W];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (!neg_reg[NUM_W][i])
            begin
                if (ov_reg[NUM_W][i] || q_reg[NUM_W][i][QW-1])
                    quo[i] = sic_pkg::POINT_MAX;
                else
                    quo[i] = q_reg[NUM_W][i];
            end
            else
            begin
                if (ov_reg[NUM_W][i] ||
                    (q_reg[NUM_W][i][QW-1] && (q_reg[NUM_W][i][QW-2:0] != '0)))
                    quo[i] = sic_pkg::POINT_MIN;
                else
                    quo[i] = -q_reg[NUM_W][i];
            end
        end
    end

endmodule

### sv/sic_back.sv
module sic_back #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    output logic                           q_pop,
    input  logic signed [COORD_BITS-1:0]   b_pt [4],
    input  logic signed [2*COORD_BITS+2:0] b_ns,
    input  logic signed [2*COORD_BITS+2:0] b_den,
    input  sic_pkg::side_t                 b_side,
    sic_res_if.source                      res_out
);

    localparam int CW  = COORD_BITS;
    localparam int DFW = CW + 1;
    localparam int DW  = 2 * CW + 3;
    localparam int H   = DW / 2;
    localparam int TW  = 3 * CW + 3;
    localparam int MW  = 3 * CW + 2;
    localparam int NW  = MW + FRAC_BITS;

    logic be;
    logic out_v_reg;

    assign be    = !out_v_reg || res_out.ready;
    assign q_pop = be && !q_empty;

    logic                 b1_v_reg, b2_v_reg, b3_v_reg, b4_v_reg;
    logic signed [CW-1:0] b1_pt_reg [4];
    logic signed [DW-1:0] b1_ns_reg, b1_den_reg, b2_den_reg, b3_den_reg, b4_den_reg;
    sic_pkg::side_t       b1_side_reg, b2_side_reg, b3_side_reg, b4_side_reg;

    logic signed [CW+H:0]         pa_lo_next [2];
    logic signed [CW+DW-H-1:0]    pa_hi_next [2];
    logic signed [H+DFW:0]        pn_lo_next [2];
    logic signed [DW-H+DFW-1:0]   pn_hi_next [2];
    logic signed [CW+H:0]         b2_pa_lo_reg [2];
    logic signed [CW+DW-H-1:0]    b2_pa_hi_reg [2];
    logic signed [H+DFW:0]        b2_pn_lo_reg [2];
    logic signed [DW-H+DFW-1:0]   b2_pn_hi_reg [2];
    logic signed [TW-1:0]         b3_sa_reg [2];
    logic signed [TW-1:0]         b3_sn_reg [2];
    logic signed [TW-1:0]         b4_t_reg [2];

    logic signed [H:0]      den_lo, ns_lo;
    logic signed [DW-H-1:0] den_hi, ns_hi;
    logic signed [DFW-1:0]  dlt [2];

    // split the wide operands so each product stays narrow
    always_comb
    begin
        den_lo = {1'b0, b1_den_reg[H-1:0]};
        den_hi = b1_den_reg[DW-1:H];
        ns_lo  = {1'b0, b1_ns_reg[H-1:0]};
        ns_hi  = b1_ns_reg[DW-1:H];
        for (int i = 0; i < 2; i++)
        begin
            dlt[i]        = DFW'(b1_pt_reg[2+i]) - DFW'(b1_pt_reg[i]);
            pa_lo_next[i] = b1_pt_reg[i] * den_lo;
            pa_hi_next[i] = b1_pt_reg[i] * den_hi;
            pn_lo_next[i] = ns_lo * dlt[i];
            pn_hi_next[i] = ns_hi * dlt[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
        end
        else if (be)
        begin
            b1_v_reg <= q_pop;
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= b2_v_reg;
            b4_v_reg <= b3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            b1_pt_reg    <= b_pt;
            b1_ns_reg    <= b_ns;
            b1_den_reg   <= b_den;
            b1_side_reg  <= b_side;
            b2_pa_lo_reg <= pa_lo_next;
            b2_pa_hi_reg <= pa_hi_next;
            b2_pn_lo_reg <= pn_lo_next;
            b2_pn_hi_reg <= pn_hi_next;
            b2_den_reg   <= b1_den_reg;
            b2_side_reg  <= b1_side_reg;
            for (int i = 0; i < 2; i++)
            begin
                b3_sa_reg[i] <= (TW'(b2_pa_hi_reg[i]) <<< H) + TW'(b2_pa_lo_reg[i]);
                b3_sn_reg[i] <= (TW'(b2_pn_hi_reg[i]) <<< H) + TW'(b2_pn_lo_reg[i]);
                b4_t_reg[i]  <= b3_sa_reg[i] + b3_sn_reg[i];
            end
            b3_den_reg  <= b2_den_reg;
            b3_side_reg <= b2_side_reg;
            b4_den_reg  <= b3_den_reg;
            b4_side_reg <= b3_side_reg;
        end
    end

    logic signed [TW-1:0] t_abs [2];
    logic [NW-1:0]        div_num [2];
    logic                 div_neg [2];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            div_neg[i] = b4_t_reg[i][TW-1];
            t_abs[i]   = div_neg[i] ? -b4_t_reg[i] : b4_t_reg[i];
            div_num[i] = NW'(t_abs[i][MW-1:0]) << FRAC_BITS;
        end
    end

    logic                               div_valid;
    logic signed [sic_pkg::POINT_W-1:0] div_quo [2];
    sic_pkg::side_t                     div_side;

    sic_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (be),
        .in_valid  (b4_v_reg),
        .num       (div_num),
        .neg       (div_neg),
        .den       (b4_den_reg),
        .side_in   (b4_side_reg),
        .out_valid (div_valid),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    sic_pkg::kind_t                     out_kind_reg;
    logic signed [sic_pkg::POINT_W-1:0] out_px_reg, out_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (be)
            out_v_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            out_kind_reg <= div_side.kind;
            out_px_reg   <= div_side.par ? div_side.ppx : div_quo[0];
            out_py_reg   <= div_side.par ? div_side.ppy : div_quo[1];
        end
    end

    assign res_out.valid   = out_v_reg;
    assign res_out.kind    = out_kind_reg;
    assign res_out.point_x = out_px_reg;
    assign res_out.point_y = out_py_reg;

endmodule

### sv/segment_intersection_classify.sv
// Classifies a pair of 2D segments ab and cd (none, proper crossing, endpoint touch,
// collinear overlap) and reports a meeting point in signed fixed point with FRAC_BITS
// fraction bits. One pair is accepted per clock when the output side keeps up; the
// pipeline holds no state between pairs. From acceptance to result a pair passes 3 front
// stages, the four-entry queue, 4 back stages, 3*COORD_BITS+3+FRAC_BITS divider stages
// and the output register. Most of the depth comes from the restoring divider, which
// resolves one quotient bit per stage for the x and y lanes side by side. The front
// stalls only when the queue is full, the back only when a result waits at the output.
module segment_intersection_classify #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sic_seg_if.sink   seg_in,
    sic_res_if.source res_out
);

    localparam int CW = COORD_BITS;
    localparam int DW = 2 * CW + 3;
    localparam int SW = $bits(sic_pkg::side_t);
    localparam int FW = 4 * CW + 2 * DW + SW;

    logic                 q_push, q_pop, q_full, q_empty;
    logic [FW-1:0]        q_wdata, q_rdata;
    logic signed [CW-1:0] f_pt [4];
    logic signed [CW-1:0] b_pt [4];
    logic signed [DW-1:0] f_ns, f_den, b_ns, b_den;
    sic_pkg::side_t       f_side, b_side;

    sic_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .seg_in (seg_in),
        .q_full (q_full),
        .q_push (q_push),
        .f_pt   (f_pt),
        .f_ns   (f_ns),
        .f_den  (f_den),
        .f_side (f_side)
    );

    assign q_wdata = {f_pt[0], f_pt[1], f_pt[2], f_pt[3], f_ns, f_den, f_side};

    sic_queue #(
        .WIDTH (FW),
        .DEPTH (sic_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign {b_pt[0], b_pt[1], b_pt[2], b_pt[3], b_ns, b_den, b_side} = q_rdata;

    sic_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .b_pt    (b_pt),
        .b_ns    (b_ns),
        .b_den   (b_den),
        .b_side  (b_side),
        .res_out (res_out)
    );

endmodule

### verif/tb_segment_intersection_classify.sv
module tb_segment_intersection_classify;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = sic_pkg::COORD_BITS_DEF;
    localparam int FW         = sic_pkg::FRAC_BITS_DEF;
    localparam int PW         = sic_pkg::POINT_W;
    localparam int N_RANDOM   = 1330;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN      = 200;

    typedef struct {
        logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    } seg_pair_t;

    typedef struct {
        sic_pkg::kind_t       kind;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
    } meet_t;

    logic clk;
    logic rst_n;

    sic_seg_if #(.COORD_BITS(CW)) seg ();
    sic_res_if                    res ();

    segment_intersection_classify #(.COORD_BITS(CW), .FRAC_BITS(FW)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg_in  (seg),
        .res_out (res)
    );

    seg_pair_t pending_pairs[$];
    meet_t     expected_meets[$];
    int        errors = 0;
    int        idle_cycles = 0;
    int        in_gap = 0;
    int        out_gap = 0;
    bit        in_quiet = 1'b0;
    bit        out_quiet = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    function automatic bit collinear(longint a0, longint a1, longint b0, longint b1,
                                     longint c0, longint c1);
        return (b0 - a0) * (c1 - a1) - (b1 - a1) * (c0 - a0) == 0;
    endfunction

    // c lies on segment ab; for a degenerate ab only y is compared
    function automatic bit lies_within(longint a0, longint a1, longint b0, longint b1,
                                       longint c0, longint c1);
        longint lo_a, lo_b, lo_c;
        if (!collinear(a0, a1, b0, b1, c0, c1))
            return 1'b0;
        lo_a = (a0 != b0) ? a0 : a1;
        lo_b = (a0 != b0) ? b0 : b1;
        lo_c = (a0 != b0) ? c0 : c1;
        return (lo_a <= lo_c && lo_c <= lo_b) || (lo_a >= lo_c && lo_c >= lo_b);
    endfunction

    // trunc((p0 + num*(p1-p0)/den) * 2^FW), saturated; den > 0
    function automatic logic signed [PW-1:0] fixed_coord(longint p0, longint p1,
                                                         longint num, longint den);
        logic signed [127:0] w0, w1, t, m, q, dd;
        bit neg;
        w0 = p0;
        w1 = num;
        dd = den;
        t = w0 * dd + w1 * (p1 - p0);
        neg = t < 0;
        m = neg ? -t : t;
        m = m <<< FW;
        q = m / dd;
        if (!neg)
            return (q > 128'sh7fff_ffff) ? sic_pkg::POINT_MAX : PW'(q);
        if (q > 128'sh8000_0000)
            return sic_pkg::POINT_MIN;
        return PW'(-q);
    endfunction

    function automatic logic signed [PW-1:0] scaled_coord(longint v);
        longint s;
        s = v * (longint'(1) <<< FW);
        if (s > 64'sh7fff_ffff)
            return sic_pkg::POINT_MAX;
        if (s < -64'sh8000_0000)
            return sic_pkg::POINT_MIN;
        return PW'(s);
    endfunction

    function automatic meet_t classify_pair(seg_pair_t p);
        meet_t  r;
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint den, ns, nt;
        ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
        cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
        r.kind = sic_pkg::KIND_NONE;
        r.px   = '0;
        r.py   = '0;
        den = ax * (dy - cy) + bx * (cy - dy) + dx * (by - ay) + cx * (ay - by);
        if (den == 0)
        begin
            if (collinear(ax, ay, bx, by, cx, cy))
            begin
                r.kind = sic_pkg::KIND_EDGE;
                if (lies_within(ax, ay, bx, by, cx, cy))
                begin
                    r.px = scaled_coord(cx); r.py = scaled_coord(cy);
                end
                else if (lies_within(ax, ay, bx, by, dx, dy))
                begin
                    r.px = scaled_coord(dx); r.py = scaled_coord(dy);
                end
                else if (lies_within(cx, cy, dx, dy, ax, ay))
                begin
                    r.px = scaled_coord(ax); r.py = scaled_coord(ay);
                end
                else if (lies_within(cx, cy, dx, dy, bx, by))
                begin
                    r.px = scaled_coord(bx); r.py = scaled_coord(by);
                end
                else
                    r.kind = sic_pkg::KIND_NONE;
            end
        end
        else
        begin
            ns = ax * (dy - cy) + cx * (ay - dy) + dx * (cy - ay);
            nt = -(ax * (cy - by) + bx * (ay - cy) + cx * (by - ay));
            if (den < 0)
            begin
                den = -den; ns = -ns; nt = -nt;
            end
            if (ns > 0 && ns < den && nt > 0 && nt < den)
                r.kind = sic_pkg::KIND_CROSS;
            else if (ns < 0 || ns > den || nt < 0 || nt > den)
                r.kind = sic_pkg::KIND_NONE;
            else
                r.kind = sic_pkg::KIND_VERTEX;
            r.px = fixed_coord(ax, bx, ns, den);
            r.py = fixed_coord(ay, by, ns, den);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic seg_pair_t make_pair(int ax, int ay, int bx, int by,
                                            int cx, int cy, int dx, int dy);
        seg_pair_t p;
        p.ax = CW'(ax); p.ay = CW'(ay); p.bx = CW'(bx); p.by = CW'(by);
        p.cx = CW'(cx); p.cy = CW'(cy); p.dx = CW'(dx); p.dy = CW'(dy);
        return p;
    endfunction

    // append one pair to the stimulus list
    function automatic void queue_pair(seg_pair_t p);
        pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    function automatic int rand_full();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int rand_span(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic int rand_edge_value();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return rand_full();
        endcase
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int px, py, vx, vy, k0, k1, k2, k3, sx, sy;
        case ($urandom_range(0, 9))
            0, 1, 2:
                p = make_pair(rand_full(), rand_full(), rand_full(), rand_full(),
                              rand_full(), rand_full(), rand_full(), rand_full());
            3, 4:
                p = make_pair(rand_span(6), rand_span(6), rand_span(6), rand_span(6),
                              rand_span(6), rand_span(6), rand_span(6), rand_span(6));
            5:
            begin
                // points along one line, overlapping or not
                px = rand_span(1000); py = rand_span(1000);
                vx = rand_span(20);   vy = rand_span(20);
                k0 = rand_span(10); k1 = rand_span(10); k2 = rand_span(10); k3 = rand_span(10);
                p = make_pair(px + k0 * vx, py + k0 * vy, px + k1 * vx, py + k1 * vy,
                              px + k2 * vx, py + k2 * vy, px + k3 * vx, py + k3 * vy);
            end
            6:
            begin
                p = make_pair(rand_full(), rand_full(), rand_full(), rand_full(),
                              rand_full(), rand_full(), rand_full(), rand_full());
                if ($urandom_range(0, 1))
                begin
                    p.cx = p.ax; p.cy = p.ay;
                end
                else
                begin
                    p.dx = p.bx; p.dy = p.by;
                end
            end
            7:
            begin
                // endpoint of cd in the middle of ab
                px = rand_span(8000); py = rand_span(8000);
                vx = rand_span(8000); vy = rand_span(8000);
                p = make_pair(px, py, px + 2 * vx, py + 2 * vy, px + vx, py + vy,
                              rand_full(), rand_full());
            end
            8:
                p = make_pair(rand_edge_value(), rand_edge_value(), rand_edge_value(),
                              rand_edge_value(), rand_edge_value(), rand_edge_value(),
                              rand_edge_value(), rand_edge_value());
            default:
            begin
                px = rand_span(10000); py = rand_span(10000);
                vx = rand_span(10000); vy = rand_span(10000);
                sx = rand_span(50);    sy = rand_span(50);
                p = make_pair(px, py, px + vx, py + vy, px + sx, py + sy,
                              px + sx + vx, py + sy + vy);
            end
        endcase
        return p;
    endfunction

    function automatic int next_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        // proper crossing, vertex touches, T-junction
        queue_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
        queue_pair(make_pair(0, 0, 10, 0, 10, 0, 10, 7));
        queue_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 9));
        queue_pair(make_pair(0, 0, 10, 0, 3, -5, 0, 0));
        // non-parallel miss, point outside the segment
        queue_pair(make_pair(0, 0, 1, 1, 5, 0, 6, -3));
        queue_pair(make_pair(0, 0, 3, 1, 7, 0, 0, 5));
        // collinear overlap, containment, disjoint; parallel apart
        queue_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
        queue_pair(make_pair(5, 5, 6, 6, 0, 0, 20, 20));
        queue_pair(make_pair(0, 0, 4, 0, 6, 0, 9, 0));
        queue_pair(make_pair(0, 0, 4, 4, 0, 1, 4, 5));
        // vertical collinear, degenerate points
        queue_pair(make_pair(3, 0, 3, 10, 3, 4, 3, 20));
        queue_pair(make_pair(2, 2, 2, 2, 2, 2, 2, 2));
        queue_pair(make_pair(2, 2, 2, 2, 0, 0, 4, 4));
        queue_pair(make_pair(7, 1, 7, 1, 0, 1, 0, 9));
        // extremes, saturation of the point
        queue_pair(make_pair(-32768, -32768, 32767, 32767,
                             -32768, 32767, 32767, -32768));
        queue_pair(make_pair(32767, 32767, 32767, -32768,
                             32767, 0, 32767, 32767));
        queue_pair(make_pair(-32768, -32768, -32768, 32767,
                             -32768, -5, -32768, -32768));
        queue_pair(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        queue_pair(make_pair(0, 0, 1, 0, 32767, -32768, 32766, 32767));
        queue_pair(make_pair(-1, -1, -1, -1, -1, -1, 0, 0));
        for (int i = 0; i < N_RANDOM; i++)
            queue_pair(random_pair());

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_pairs.size() == 0 && !seg.valid);
        wait (expected_meets.size() == 0);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0 && expected_meets.size() == 0)
            $display("** segment_intersection_classify: PASSED **");
        else
            $display("** segment_intersection_classify: FAILED **");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        seg_pair_t nxt;
        seg_pair_t cur;
        if (rst_n)
        begin
            if (seg.valid && seg.ready)
            begin
                cur.ax = seg.ax; cur.ay = seg.ay; cur.bx = seg.bx; cur.by = seg.by;
                cur.cx = seg.cx; cur.cy = seg.cy; cur.dx = seg.dx; cur.dy = seg.dy;
                expected_meets.insert(expected_meets.size(), classify_pair(cur));
            end
            if ($urandom_range(0, 299) == 0)
                in_quiet = ~in_quiet;
            if (!seg.valid || seg.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap = in_gap - 1;
                    seg.valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    nxt = pending_pairs.pop_front();
                    seg.ax <= nxt.ax; seg.ay <= nxt.ay; seg.bx <= nxt.bx; seg.by <= nxt.by;
                    seg.cx <= nxt.cx; seg.cy <= nxt.cy; seg.dx <= nxt.dx; seg.dy <= nxt.dy;
                    seg.valid <= 1'b1;
                    in_gap = next_gap(in_quiet);
                end
                else
                    seg.valid <= 1'b0;
            end
        end
        else
        begin
            seg.valid <= 1'b0;
            seg.ax <= '0; seg.ay <= '0; seg.bx <= '0; seg.by <= '0;
            seg.cx <= '0; seg.cy <= '0; seg.dx <= '0; seg.dy <= '0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        meet_t want;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (expected_meets.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d x=%0d y=%0d", $realtime,
                             res.kind, res.point_x, res.point_y);
                    errors++;
                end
                else
                begin
                    want = expected_meets.pop_front();
                    if (res.kind !== want.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d", $realtime,
                                 want.kind, res.kind);
                        errors++;
                    end
                    if (res.point_x !== want.px)
                    begin
                        $display("%0t: point_x expected %0d actual %0d", $realtime,
                                 want.px, res.point_x);
                        errors++;
                    end
                    if (res.point_y !== want.py)
                    begin
                        $display("%0t: point_y expected %0d actual %0d", $realtime,
                                 want.py, res.point_y);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 299) == 0)
                out_quiet = ~out_quiet;
            if (out_gap > 0)
            begin
                out_gap = out_gap - 1;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= 1'b1;
                out_gap = next_gap(out_quiet);
            end
        end
        else
            res.ready <= 1'b0;
    end

    // ---------------------------------------------------------------
    // Watchdog: cycles without any item moving
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((seg.valid && seg.ready) || (res.valid && res.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
                $display("** segment_intersection_classify: FAILED **");
                $finish;
            end
        end
    end

endmodule
